### hw/rtl/cpio_hp_pkg.sv
package cpio_hp_pkg;

  localparam int unsigned ODC_FIELDS  = 10;
  localparam int unsigned NEWC_FIELDS = 13;
  localparam int unsigned MAGIC_LEN   = 6;
  localparam int unsigned QUEUE_DEPTH = 3;

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_MAGIC  = 2'd1,
    PH_FIELDS = 2'd2,
    PH_DONE   = 2'd3
  } phase_t;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_BAD_DIGIT = 2'd1;
  localparam logic [1:0] ST_BAD_MAGIC = 2'd2;

  // header formats
  localparam logic FMT_ODC  = 1'b0;
  localparam logic FMT_NEWC = 1'b1;

  // field ids
  localparam logic [3:0] FID_DEVMAJOR  = 4'd0;
  localparam logic [3:0] FID_DEVMINOR  = 4'd1;
  localparam logic [3:0] FID_INO       = 4'd2;
  localparam logic [3:0] FID_MODE      = 4'd3;
  localparam logic [3:0] FID_UID       = 4'd4;
  localparam logic [3:0] FID_GID       = 4'd5;
  localparam logic [3:0] FID_NLINK     = 4'd6;
  localparam logic [3:0] FID_RDEVMAJOR = 4'd7;
  localparam logic [3:0] FID_RDEVMINOR = 4'd8;
  localparam logic [3:0] FID_MTIME     = 4'd9;
  localparam logic [3:0] FID_NAMESIZE  = 4'd10;
  localparam logic [3:0] FID_FILESIZE  = 4'd11;
  localparam logic [3:0] FID_CHECK     = 4'd12;

  // ASCII characters
  localparam logic [7:0] CH_0  = 8'h30;
  localparam logic [7:0] CH_1  = 8'h31;
  localparam logic [7:0] CH_7  = 8'h37;
  localparam logic [7:0] CH_8  = 8'h38;
  localparam logic [7:0] CH_9  = 8'h39;
  localparam logic [7:0] CH_UA = 8'h41;
  localparam logic [7:0] CH_UF = 8'h46;
  localparam logic [7:0] CH_LA = 8'h61;
  localparam logic [7:0] CH_LF = 8'h66;

  localparam logic [3:0] NEWC_DIGITS = 4'd8;

  typedef struct packed {
    logic [3:0]  field_id;
    logic [31:0] field_value;
    logic [1:0]  status;
    logic        header_format;
    logic        last;
  } res_t;

  // up to two results produced by one byte
  typedef struct packed {
    logic v0;
    logic v1;
    res_t r0;
    res_t r1;
  } push_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } digit_t;

  function automatic logic [3:0] odc_id(input logic [3:0] slot);
    logic [3:0] id;
    case (slot)
      4'd0:    id = FID_DEVMAJOR;
      4'd1:    id = FID_INO;
      4'd2:    id = FID_MODE;
      4'd3:    id = FID_UID;
      4'd4:    id = FID_GID;
      4'd5:    id = FID_NLINK;
      4'd6:    id = FID_RDEVMAJOR;
      4'd7:    id = FID_MTIME;
      4'd8:    id = FID_NAMESIZE;
      4'd9:    id = FID_FILESIZE;
      default: id = FID_DEVMAJOR;
    endcase
    return id;
  endfunction

  function automatic logic [3:0] odc_len(input logic [3:0] slot);
    logic [3:0] len;
    case (slot)
      4'd7, 4'd9: len = 4'd11;
      default:    len = 4'd6;
    endcase
    return len;
  endfunction

  function automatic logic [3:0] newc_id(input logic [3:0] slot);
    logic [3:0] id;
    case (slot)
      4'd0:    id = FID_INO;
      4'd1:    id = FID_MODE;
      4'd2:    id = FID_UID;
      4'd3:    id = FID_GID;
      4'd4:    id = FID_NLINK;
      4'd5:    id = FID_MTIME;
      4'd6:    id = FID_FILESIZE;
      4'd7:    id = FID_DEVMAJOR;
      4'd8:    id = FID_DEVMINOR;
      4'd9:    id = FID_RDEVMAJOR;
      4'd10:   id = FID_RDEVMINOR;
      4'd11:   id = FID_NAMESIZE;
      4'd12:   id = FID_CHECK;
      default: id = FID_DEVMAJOR;
    endcase
    return id;
  endfunction

  // expected magic character at a position, per form
  function automatic logic [7:0] magic_char(input logic newc, input logic [2:0] pos);
    logic [7:0] ch;
    case (pos)
      3'd0, 3'd2, 3'd4: ch = CH_0;
      3'd1, 3'd3:       ch = CH_7;
      default:          ch = newc ? CH_1 : CH_7;
    endcase
    return ch;
  endfunction

  function automatic digit_t digit_val(input logic [7:0] b, input logic newc);
    digit_t d;
    d.ok  = 1'b0;
    d.val = b[3:0];
    if (b >= CH_0 && b <= CH_7) begin
      d.ok = 1'b1;
    end else if (newc && (b == CH_8 || b == CH_9)) begin
      d.ok = 1'b1;
    end else if (newc && ((b >= CH_LA && b <= CH_LF) || (b >= CH_UA && b <= CH_UF))) begin
      d.ok  = 1'b1;
      d.val = b[3:0] + 4'd9;
    end
    return d;
  endfunction

endpackage

### hw/rtl/cpio_hp_if.sv
interface cpio_hp_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first;

  modport source (output valid, output data_byte, output first, input ready);
  modport sink   (input valid, input data_byte, input first, output ready);
endinterface

interface cpio_hp_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  field_id;
  logic [31:0] field_value;
  logic [1:0]  status;
  logic        header_format;
  logic        last;

  modport source (output valid, output field_id, output field_value, output status,
                  output header_format, output last, input ready);
  modport sink   (input valid, input field_id, input field_value, input status,
                  input header_format, input last, output ready);
endinterface

### hw/rtl/cpio_hp_parse.sv
module cpio_hp_parse (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          in_data_byte,
  input  logic                in_first,
  input  logic                room,
  output cpio_hp_pkg::push_t  push
);

  // input register
  logic       in_v_r, in_v_nxt;
  logic [7:0] byte_r;
  logic       first_r;
  logic       adv;

  // parser state
  cpio_hp_pkg::phase_t phase_r, phase_nxt;
  logic [2:0]  pos_r, pos_nxt;
  logic        fmt_r, fmt_nxt;
  logic [1:0]  match_r, match_nxt;
  logic [31:0] acc_r, acc_nxt;
  logic [3:0]  dcnt_r, dcnt_nxt;
  logic [3:0]  slot_r, slot_nxt;

  // working copies after a first mark restarts the parser
  cpio_hp_pkg::phase_t ph;
  logic [2:0]  pos;
  logic [1:0]  match;
  logic [3:0]  id, len, nfields;
  cpio_hp_pkg::digit_t dg;
  logic [31:0] acc_sh;
  logic        lst;

  assign adv      = in_v_r && room;
  assign in_ready = !in_v_r || room;
  assign in_v_nxt = (in_valid && in_ready) ? 1'b1 : (adv ? 1'b0 : in_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= in_v_nxt;
    end
    if (in_valid && in_ready) begin
      byte_r  <= in_data_byte;
      first_r <= in_first;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= cpio_hp_pkg::PH_IDLE;
      pos_r   <= 3'd0;
      fmt_r   <= cpio_hp_pkg::FMT_ODC;
      match_r <= 2'b11;
      acc_r   <= 32'd0;
      dcnt_r  <= 4'd0;
      slot_r  <= 4'd0;
    end else begin
      phase_r <= phase_nxt;
      pos_r   <= pos_nxt;
      fmt_r   <= fmt_nxt;
      match_r <= match_nxt;
      acc_r   <= acc_nxt;
      dcnt_r  <= dcnt_nxt;
      slot_r  <= slot_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pos_nxt   = pos_r;
    fmt_nxt   = fmt_r;
    match_nxt = match_r;
    acc_nxt   = acc_r;
    dcnt_nxt  = dcnt_r;
    slot_nxt  = slot_r;
    push      = '0;

    ph    = first_r ? cpio_hp_pkg::PH_MAGIC : phase_r;
    pos   = first_r ? 3'd0 : pos_r;
    match = first_r ? 2'b11 : match_r;

    nfields = fmt_r ? 4'(cpio_hp_pkg::NEWC_FIELDS) : 4'(cpio_hp_pkg::ODC_FIELDS);
    id      = fmt_r ? cpio_hp_pkg::newc_id(slot_r) : cpio_hp_pkg::odc_id(slot_r);
    len     = fmt_r ? cpio_hp_pkg::NEWC_DIGITS : cpio_hp_pkg::odc_len(slot_r);
    dg      = cpio_hp_pkg::digit_val(byte_r, fmt_r);
    acc_sh  = fmt_r ? {acc_r[27:0], dg.val} : {acc_r[28:0], dg.val[2:0]};
    lst     = (slot_r + 4'd1) == nfields;

    if (adv) begin
      if (first_r) begin
        phase_nxt = cpio_hp_pkg::PH_MAGIC;
        pos_nxt   = 3'd0;
        fmt_nxt   = cpio_hp_pkg::FMT_ODC;
        match_nxt = 2'b11;
        acc_nxt   = 32'd0;
        dcnt_nxt  = 4'd0;
        slot_nxt  = 4'd0;
      end
      case (ph)
        cpio_hp_pkg::PH_MAGIC: begin
          if (byte_r != cpio_hp_pkg::magic_char(cpio_hp_pkg::FMT_ODC, pos)) begin
            match[0] = 1'b0;
          end
          if (byte_r != cpio_hp_pkg::magic_char(cpio_hp_pkg::FMT_NEWC, pos)) begin
            match[1] = 1'b0;
          end
          match_nxt = match;
          pos_nxt   = pos + 3'd1;
          if (pos == 3'(cpio_hp_pkg::MAGIC_LEN - 1)) begin
            acc_nxt  = 32'd0;
            dcnt_nxt = 4'd0;
            slot_nxt = 4'd0;
            if (match[0]) begin
              fmt_nxt   = cpio_hp_pkg::FMT_ODC;
              phase_nxt = cpio_hp_pkg::PH_FIELDS;
            end else if (match[1]) begin
              fmt_nxt   = cpio_hp_pkg::FMT_NEWC;
              phase_nxt = cpio_hp_pkg::PH_FIELDS;
            end else begin
              fmt_nxt   = cpio_hp_pkg::FMT_ODC;
              phase_nxt = cpio_hp_pkg::PH_DONE;
              push.v0   = 1'b1;
              push.r0   = '{field_id: cpio_hp_pkg::FID_DEVMAJOR, field_value: 32'd0,
                            status: cpio_hp_pkg::ST_BAD_MAGIC,
                            header_format: cpio_hp_pkg::FMT_ODC, last: 1'b1};
            end
          end
        end
        cpio_hp_pkg::PH_FIELDS: begin
          if (slot_r >= nfields) begin
            phase_nxt = cpio_hp_pkg::PH_DONE;
          end else if (!dg.ok) begin
            phase_nxt = cpio_hp_pkg::PH_DONE;
            push.v0   = 1'b1;
            push.r0   = '{field_id: id, field_value: 32'd0,
                          status: cpio_hp_pkg::ST_BAD_DIGIT,
                          header_format: fmt_r, last: 1'b1};
          end else if ((dcnt_r + 4'd1) < len) begin
            acc_nxt  = acc_sh;
            dcnt_nxt = dcnt_r + 4'd1;
          end else begin
            acc_nxt  = 32'd0;
            dcnt_nxt = 4'd0;
            slot_nxt = slot_r + 4'd1;
            if (lst) begin
              phase_nxt = cpio_hp_pkg::PH_DONE;
            end
            push.v0 = 1'b1;
            push.r0 = '{field_id: id, field_value: acc_sh, status: cpio_hp_pkg::ST_OK,
                        header_format: fmt_r, last: lst};
            // odc has no minor fields: insert them as zero
            if (fmt_r == cpio_hp_pkg::FMT_ODC &&
                (id == cpio_hp_pkg::FID_DEVMAJOR || id == cpio_hp_pkg::FID_RDEVMAJOR)) begin
              push.v1 = 1'b1;
              push.r1 = '{field_id: id + 4'd1, field_value: 32'd0,
                          status: cpio_hp_pkg::ST_OK,
                          header_format: cpio_hp_pkg::FMT_ODC, last: 1'b0};
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

endmodule

### hw/rtl/cpio_hp_outq.sv
module cpio_hp_outq (
  input  logic               clk,
  input  logic               rst_n,
  input  cpio_hp_pkg::push_t push,
  output logic               room,
  output logic               out_valid,
  input  logic               out_ready,
  output cpio_hp_pkg::res_t  out_res
);

  cpio_hp_pkg::res_t q_r [cpio_hp_pkg::QUEUE_DEPTH];
  logic [1:0] head_r, head_nxt;
  logic [1:0] tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;
  logic [1:0] tail_p1;

  function automatic logic [1:0] inc3(input logic [1:0] p);
    return (p == 2'(cpio_hp_pkg::QUEUE_DEPTH - 1)) ? 2'd0 : p + 2'd1;
  endfunction

  // room for two words, judged on the registered level
  assign room      = cnt_r <= 2'd1;
  assign out_valid = cnt_r != 2'd0;
  assign out_res   = q_r[head_r];
  assign pop       = out_valid && out_ready;
  assign tail_p1   = inc3(tail_r);

  always_comb begin
    head_nxt = pop ? inc3(head_r) : head_r;
    tail_nxt = push.v1 ? inc3(tail_p1) : (push.v0 ? tail_p1 : tail_r);
    cnt_nxt  = cnt_r + {1'b0, push.v0} + {1'b0, push.v1} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r <= 2'd0;
      tail_r <= 2'd0;
      cnt_r  <= 2'd0;
    end else begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      cnt_r  <= cnt_nxt;
    end
    if (push.v0) begin
      q_r[tail_r] <= push.r0;
    end
    if (push.v1) begin
      q_r[tail_p1] <= push.r1;
    end
  end

endmodule

### hw/rtl/cpio_header_parser_top.sv
// cpio header parser (odc and newc forms).
// Input channel in_ch: one header byte per word, with first set on the first
// magic byte of each header; first restarts the parser at any point.
// Output channel out_ch: one decoded field per word (id, 32-bit value,
// status, format, last). last marks the final word of a header.
// Path: a taken byte is held in the input register, decoded from there and
// written into the output queue, from which its words are offered.
// Throughput: one byte per cycle while the queue has room. An odc devmajor
// or rdevmajor byte yields two words (the major plus a zero minor); that can
// stall the input while the three-word output queue drains.
// Magic errors are reported on the sixth magic byte; bad digits end the
// header with one error word. Later bytes are dropped until the next first.
// Reset (rst_n low, synchronous) empties the input register and the output
// queue and returns the parser to idle: bytes before a first are ignored.
// Receiver stall: words wait in the queue; in_ch.ready drops once a byte is
// waiting in the input register and the queue holds two or more words,
// taken from the registered fill level only.
module cpio_header_parser_top (
  input  logic          clk,
  input  logic          rst_n,
  cpio_hp_in_if.sink    in_ch,
  cpio_hp_out_if.source out_ch
);

  cpio_hp_pkg::push_t push;
  cpio_hp_pkg::res_t  out_res;
  logic               room;

  // input register, parser state and field decode
  cpio_hp_parse u_parse (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_ch.valid),
    .in_ready     (in_ch.ready),
    .in_data_byte (in_ch.data_byte),
    .in_first     (in_ch.first),
    .room         (room),
    .push         (push)
  );

  // result queue: takes up to two words a cycle, gives one
  cpio_hp_outq u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room      (room),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_res   (out_res)
  );

  assign out_ch.field_id      = out_res.field_id;
  assign out_ch.field_value   = out_res.field_value;
  assign out_ch.status        = out_res.status;
  assign out_ch.header_format = out_res.header_format;
  assign out_ch.last          = out_res.last;

  // a second word is only the inserted odc minor, right after its major
  a_minor_follows_major: assert property (@(posedge clk) disable iff (!rst_n)
    push.v1 |-> (push.v0 && push.r1.field_id == push.r0.field_id + 4'd1 &&
                 push.r1.field_value == 32'd0 &&
                 push.r0.header_format == cpio_hp_pkg::FMT_ODC))
    else $error("inserted minor does not follow its major");

  // error words always close the header and come alone
  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (push.v0 && push.r0.status != cpio_hp_pkg::ST_OK) |-> (push.r0.last && !push.v1))
    else $error("error word not marked last");

  // the parser only produces words when the queue had room
  a_push_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    push.v0 |-> room)
    else $error("word pushed into a full queue");

endmodule

### bench/cpio_field_checker.sv
`timescale 1ns / 1ps

module cpio_field_checker
  import cpio_hp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  cpio_hp_in_if       in_ch,
  cpio_hp_out_if      out_ch,
  output int unsigned fail_count,
  output int unsigned pending,
  output int unsigned words_checked
);

  localparam logic [47:0] ODC_MAGIC  = "070707";
  localparam logic [47:0] NEWC_MAGIC = "070701";
  localparam int          MAX_REPORTS = 20;

  // field id per slot, slot 0 in the low nibble
  localparam logic [39:0] ODC_IDS = {FID_FILESIZE, FID_NAMESIZE, FID_MTIME, FID_RDEVMAJOR,
                                     FID_NLINK, FID_GID, FID_UID, FID_MODE, FID_INO,
                                     FID_DEVMAJOR};
  localparam logic [51:0] NEWC_IDS = {FID_CHECK, FID_NAMESIZE, FID_RDEVMINOR, FID_RDEVMAJOR,
                                      FID_DEVMINOR, FID_DEVMAJOR, FID_FILESIZE, FID_MTIME,
                                      FID_NLINK, FID_GID, FID_UID, FID_MODE, FID_INO};

  res_t        due_fields[$];
  int unsigned n_fail;
  int unsigned n_checked;

  // parser state as predicted
  phase_t      ph;
  logic [6:0]  mpos;
  logic        fmt;
  logic [1:0]  mmatch;
  logic [31:0] acc;
  logic [3:0]  ndig;
  logic [3:0]  slot;

  initial begin
    n_fail    = 0;
    n_checked = 0;
  end

  function automatic void expect_word(input logic [3:0] id, input logic [31:0] val,
                                      input logic [1:0] st, input logic f, input logic lst);
    res_t w;
    w = {id, val, st, f, lst};
    due_fields.push_back(w);
  endfunction

  always @(posedge clk) begin : decode_model
    res_t       got;
    res_t       want;
    logic [7:0] b;
    logic [2:0] mp;
    logic       dig_ok;
    logic [3:0] dig;
    logic [3:0] fid;
    int         flen;
    int         nfld;
    logic       final_fld;
    if (!rst_n) begin
      due_fields.delete();
      ph     = PH_IDLE;
      mpos   = '0;
      fmt    = FMT_ODC;
      mmatch = 2'b11;
      acc    = '0;
      ndig   = '0;
      slot   = '0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.field_id, out_ch.field_value, out_ch.status,
               out_ch.header_format, out_ch.last};
        n_checked++;
        if (due_fields.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: unexpected word id %0d value %h status %0d fmt %0d last %0d",
                     $time, got.field_id, got.field_value, got.status,
                     got.header_format, got.last);
        end else begin
          want = due_fields.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS)
              $display({"%0t: word mismatch, expected id %0d value %h status %0d fmt %0d ",
                        "last %0d, got id %0d value %h status %0d fmt %0d last %0d"},
                       $time, want.field_id, want.field_value, want.status,
                       want.header_format, want.last, got.field_id, got.field_value,
                       got.status, got.header_format, got.last);
          end
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        b = in_ch.data_byte;
        if (in_ch.first) begin
          ph     = PH_MAGIC;
          mpos   = '0;
          fmt    = FMT_ODC;
          mmatch = 2'b11;
          acc    = '0;
          ndig   = '0;
          slot   = '0;
        end
        if (ph == PH_MAGIC) begin
          mp = (mpos > 7'd5) ? 3'd5 : mpos[2:0];
          if (b != ODC_MAGIC[47 - 8*mp -: 8]) mmatch[0] = 1'b0;
          if (b != NEWC_MAGIC[47 - 8*mp -: 8]) mmatch[1] = 1'b0;
          mpos = mpos + 7'd1;
          if (mpos == 7'(MAGIC_LEN)) begin
            acc  = '0;
            ndig = '0;
            slot = '0;
            if (mmatch[0]) begin
              fmt = FMT_ODC;
              ph  = PH_FIELDS;
            end else if (mmatch[1]) begin
              fmt = FMT_NEWC;
              ph  = PH_FIELDS;
            end else begin
              fmt = FMT_ODC;
              ph  = PH_DONE;
              expect_word(FID_DEVMAJOR, '0, ST_BAD_MAGIC, FMT_ODC, 1'b1);
            end
          end
        end else if (ph == PH_FIELDS) begin
          nfld = (fmt == FMT_NEWC) ? NEWC_FIELDS : ODC_FIELDS;
          if (slot >= nfld) begin
            ph = PH_DONE;
          end else begin
            fid  = (fmt == FMT_NEWC) ? NEWC_IDS[slot*4 +: 4] : ODC_IDS[slot*4 +: 4];
            flen = (fmt == FMT_NEWC) ? 8 : ((slot == 4'd7 || slot == 4'd9) ? 11 : 6);
            dig_ok = 1'b1;
            dig    = '0;
            if (b >= CH_0 && b <= CH_7)
              dig = 4'(b - CH_0);
            else if (fmt == FMT_NEWC && (b == CH_8 || b == CH_9))
              dig = 4'(b - CH_0);
            else if (fmt == FMT_NEWC && b >= CH_LA && b <= CH_LF)
              dig = 4'(b - CH_LA + 8'd10);
            else if (fmt == FMT_NEWC && b >= CH_UA && b <= CH_UF)
              dig = 4'(b - CH_UA + 8'd10);
            else
              dig_ok = 1'b0;
            if (!dig_ok) begin
              ph = PH_DONE;
              expect_word(fid, '0, ST_BAD_DIGIT, fmt, 1'b1);
            end else begin
              acc  = (fmt == FMT_NEWC) ? {acc[27:0], dig} : {acc[28:0], dig[2:0]};
              ndig = ndig + 4'd1;
              if (ndig == flen) begin
                final_fld = (slot + 1 == nfld);
                expect_word(fid, acc, ST_OK, fmt, final_fld);
                // odc has no minor fields: a zero minor follows each major
                if (fmt == FMT_ODC && (fid == FID_DEVMAJOR || fid == FID_RDEVMAJOR))
                  expect_word(fid + 4'd1, '0, ST_OK, FMT_ODC, 1'b0);
                acc  = '0;
                ndig = '0;
                slot = slot + 4'd1;
                if (final_fld) ph = PH_DONE;
              end
            end
          end
        end
      end
    end
    fail_count    <= n_fail;
    pending       <= due_fields.size();
    words_checked <= n_checked;
  end

endmodule

### bench/tb_cpio_header_parser_top.sv
`timescale 1ns / 1ps

module tb_cpio_header_parser_top;
  import cpio_hp_pkg::*;

  localparam logic [47:0] ODC_MAGIC  = "070707";
  localparam logic [47:0] NEWC_MAGIC = "070701";
  localparam int ODC_DIGITS  = 70;
  localparam int NEWC_DIGITS_ALL = 104;
  localparam int LIVE_TARGET = 1924;  // directed bytes plus the random part
  localparam int HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int HOLD_AT     = 40;    // word count at which the hold-off starts
  localparam int TAIL_CYCLES = 20;

  logic clk;
  logic rst_n;

  cpio_hp_in_if  in_ch();
  cpio_hp_out_if out_ch();

  int unsigned fail_count;
  int unsigned pending;
  int unsigned words_checked;

  // set by the receiver during its long hold-off, so the sender keeps pushing
  logic rx_hold;
  bit   quiet_tx;
  bit   quiet_rx;

  int live_bytes;
  int n_odc, n_newc, n_bad_digit, n_bad_magic, n_cut;

  cpio_header_parser_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  cpio_field_checker i_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .fail_count    (fail_count),
    .pending       (pending),
    .words_checked (words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Offer one byte after a random gap and hold it until taken. Changes are
  // made at the falling edge; the handshake is sampled at the rising edge.
  // valid is only lowered when a gap is drawn, so a back-to-back word never
  // sees two writes to valid in one step.
  task automatic send_byte(input logic [7:0] b, input logic f, input bit live);
    int gap;
    gap = (quiet_tx || rx_hold) ? 0 : $urandom_range(0, 9);
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= b;
    in_ch.first     <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (live) live_bytes++;
  endtask

  // Magic, then the digit stream of the chosen form. bad_at puts an illegal
  // byte at that digit index and ends the header there; stop_at simply stops
  // sending, leaving the header open for the next first mark to abandon.
  task automatic send_header(input bit newc, input int bad_at, input int stop_at);
    int         n_digits;
    int         fld;
    int         pos;
    int         flen;
    int         style;
    int         v;
    logic [7:0] b;
    for (int k = 0; k < MAGIC_LEN; k++)
      send_byte(newc ? NEWC_MAGIC[47 - 8*k -: 8] : ODC_MAGIC[47 - 8*k -: 8], k == 0, 1'b1);
    n_digits = newc ? NEWC_DIGITS_ALL : ODC_DIGITS;
    fld      = 0;
    pos      = 0;
    style    = 2;
    for (int i = 0; i < n_digits; i++) begin
      if (i == stop_at) break;
      flen = newc ? 8 : ((fld == 7 || fld == 9) ? 11 : 6);
      // per field: all zeros, all top digits (wraps the long octal ones), or random
      if (pos == 0) style = $urandom_range(0, 5);
      if (i == bad_at) begin
        if (!newc && $urandom_range(0, 1) == 1) begin
          // legal in newc only, so the octal form must reject it
          b = $urandom_range(0, 1) ? CH_8 : CH_LA;
        end else begin
          b = 8'($urandom_range(0, 255));
          while ((b >= CH_0 && b <= CH_7) ||
                 (newc && (b == CH_8 || b == CH_9 || (b >= CH_LA && b <= CH_LF) ||
                           (b >= CH_UA && b <= CH_UF))))
            b = 8'($urandom_range(0, 255));
        end
        send_byte(b, 1'b0, 1'b1);
        break;
      end
      v = (style == 0) ? 0 : (style == 1) ? (newc ? 15 : 7) : $urandom_range(0, newc ? 15 : 7);
      if (v < 10) b = 8'(CH_0 + v);
      else        b = 8'(($urandom_range(0, 1) ? CH_UA : CH_LA) + v - 10);
      send_byte(b, 1'b0, 1'b1);
      pos++;
      if (pos == flen) begin
        pos = 0;
        fld++;
      end
    end
  endtask

  // Receiver: random stall before every word, calm stretches now and then,
  // and one long hold-off so the output queue fills and the input stalls.
  initial begin : result_sink
    int stall;
    int taken;
    out_ch.ready = 1'b0;
    rx_hold      = 1'b0;
    quiet_rx     = 1'b0;
    taken        = 0;
    wait (rst_n === 1'b1);
    forever begin
      if (taken % 32 == 0) quiet_rx = ($urandom_range(0, 3) == 0);
      stall = quiet_rx ? 0 : $urandom_range(0, 9);
      if (taken == HOLD_AT) stall = HOLD_CYCLES;
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        if (taken == HOLD_AT) rx_hold <= 1'b1;
        repeat (stall) @(negedge clk);
        rx_hold <= 1'b0;
      end
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!out_ch.valid) @(posedge clk);
      taken++;
    end
  end

  initial begin : byte_source
    int kind;
    int hdr;
    bit newc;
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'h00;
    in_ch.first     = 1'b0;
    quiet_tx        = 1'b0;
    live_bytes      = 0;
    n_odc           = 0;
    n_newc          = 0;
    n_bad_digit     = 0;
    n_bad_magic     = 0;
    n_cut           = 0;
    hdr             = 0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // --- directed ---
    // stray bytes before any first mark: dropped
    send_byte(8'h00, 1'b0, 1'b0);
    send_byte(8'hFF, 1'b0, 1'b0);
    // wrong first magic character: one bad-magic word on the sixth byte
    send_byte("1", 1'b1, 1'b1);
    for (int k = 1; k < MAGIC_LEN; k++) send_byte(ODC_MAGIC[47 - 8*k -: 8], 1'b0, 1'b1);
    n_bad_magic++;
    // restart mid-magic, newc header, then an illegal hex digit in ino
    send_byte(CH_0, 1'b1, 1'b1);
    send_byte(CH_7, 1'b0, 1'b1);
    for (int k = 0; k < MAGIC_LEN; k++) send_byte(NEWC_MAGIC[47 - 8*k -: 8], k == 0, 1'b1);
    send_byte("g", 1'b0, 1'b1);
    // odc header whose devmajor starts with an 8: not an octal digit
    for (int k = 0; k < MAGIC_LEN; k++) send_byte(ODC_MAGIC[47 - 8*k -: 8], k == 0, 1'b1);
    send_byte(CH_8, 1'b0, 1'b1);
    n_bad_digit += 2;

    // --- random: mostly well-formed headers, the rest broken or noise ---
    while (live_bytes < LIVE_TARGET) begin
      quiet_tx = ($urandom_range(0, 3) == 0);
      kind     = $urandom_range(0, 99);
      newc     = 1'($urandom_range(0, 1));
      if (kind < 35) begin
        send_header(1'b0, -1, -1);
        n_odc++;
      end else if (kind < 70) begin
        send_header(1'b1, -1, -1);
        n_newc++;
      end else if (kind < 80) begin
        send_header(newc, $urandom_range(0, (newc ? NEWC_DIGITS_ALL : ODC_DIGITS) - 1), -1);
        n_bad_digit++;
      end else if (kind < 88) begin
        // left unfinished; the next first mark drops it without a word
        send_header(newc, -1, $urandom_range(1, (newc ? NEWC_DIGITS_ALL : ODC_DIGITS) - 1));
        n_cut++;
      end else if (kind < 96) begin
        // one magic byte replaced at random; may still match by chance
        begin : corrupt_magic
          int pos;
          pos = $urandom_range(0, MAGIC_LEN - 1);
          for (int k = 0; k < MAGIC_LEN; k++)
            send_byte((k == pos) ? 8'($urandom_range(0, 255)) :
                      (newc ? NEWC_MAGIC[47 - 8*k -: 8] : ODC_MAGIC[47 - 8*k -: 8]),
                      k == 0, 1'b1);
        end
        n_bad_magic++;
      end else begin
        repeat ($urandom_range(1, 5)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      end
      // trailing bytes after a finished header are dropped (skipped after a
      // cut header, where they would be read as digits)
      if (kind < 80 && $urandom_range(0, 2) == 0)
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      hdr++;
      // now and then let the block drain completely before the next header
      if (hdr % 10 == 5) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(posedge clk);
      end
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d header bytes: %0d odc and %0d newc complete headers,",
             live_bytes, n_odc, n_newc);
    $display("%0d bad-digit, %0d bad-magic, %0d abandoned headers; %0d words checked",
             n_bad_digit, n_bad_magic, n_cut, words_checked);
    if (pending != 0)
      $display("%0t: %0d expected words never arrived", $time, pending);
    if (fail_count == 0 && pending == 0) begin
      $display("[cpio_header_parser_top] OK");
    end else begin
      $display("[cpio_header_parser_top] ERROR");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #2000000;
    $display("%0t: timeout", $time);
    $display("[cpio_header_parser_top] ERROR");
    $finish;
  end

endmodule

### cpio_header_parser_top.f
hw/rtl/cpio_hp_pkg.sv
hw/rtl/cpio_hp_if.sv
hw/rtl/cpio_hp_parse.sv
hw/rtl/cpio_hp_outq.sv
hw/rtl/cpio_header_parser_top.sv
bench/cpio_field_checker.sv
bench/tb_cpio_header_parser_top.sv
